### hw/rtl/asn1_time_string_parser_unit_defines.svh
// ---------------------------------------------------------------------------
// ASN.1 time string parser assertion macros
// Concurrent assertion helpers; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASN1_TIME_STRING_PARSER_UNIT_DEFINES_SVH
`define ASN1_TIME_STRING_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define ASN1TP_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("asn1tp assertion failed");
`define ASN1TP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("asn1tp assertion failed");
`else
`define ASN1TP_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define ASN1TP_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

### hw/rtl/asn1tp_pkg.sv
// ---------------------------------------------------------------------------
// ASN.1 time string parser package
// Parse state type, character codes, string positions and result codes.
// ---------------------------------------------------------------------------
`default_nettype none

package asn1tp_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_Z     = 8'h5a;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    localparam logic [4:0] POS_START     = 5'd0;
    localparam logic [4:0] POS_CENT_LO   = 5'd1;
    localparam logic [4:0] POS_YEAR_HI   = 5'd2;
    localparam logic [4:0] POS_AFTER_MIN = 5'd12;
    localparam logic [4:0] POS_SEC_LO    = 5'd13;
    localparam logic [4:0] POS_AFTER_SEC = 5'd14;
    localparam logic [4:0] POS_OFF_H_HI  = 5'd15;
    localparam logic [4:0] POS_OFF_H_LO  = 5'd16;
    localparam logic [4:0] POS_OFF_M_HI  = 5'd17;
    localparam logic [4:0] POS_OFF_M_LO  = 5'd18;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [1:0] ZONE_NONE    = 2'd0;
    localparam logic [1:0] ZONE_UTC     = 2'd1;
    localparam logic [1:0] ZONE_NUMERIC = 2'd2;

    localparam int NUM_FIELDS = 6;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic [4:0]                 position;
        logic                       gen_fmt;
        logic [3:0]                 tens;
        logic [6:0]                 century;
        logic [NUM_FIELDS-1:0][6:0] fields;
        logic [1:0]                 zone;
        logic                       off_sign;
        logic [6:0]                 off_hours;
        logic [6:0]                 off_mins;
        logic [1:0]                 err;
        logic                       done;
    } t_state;

    localparam t_state STATE_RESET = '0;

endpackage

`default_nettype wire

### hw/rtl/asn1tp_byte_step.sv
// ---------------------------------------------------------------------------
// ASN.1 time string parser byte step
// Next parse state from the current state and one string byte.
// ---------------------------------------------------------------------------
`default_nettype none

module asn1tp_byte_step (
    input  var asn1tp_pkg::t_state i_state,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_gen_fmt,
    output asn1tp_pkg::t_state     o_state
);

    logic [4:0] pos;
    logic [3:0] digit;
    logic [6:0] pair;
    logic [4:0] field_off;
    logic [2:0] field_idx;
    logic       is_digit;
    logic       is_z;
    logic       is_sign;
    logic       zone_slot;

    assign digit     = i_char[3:0];
    assign is_digit  = (i_char >= asn1tp_pkg::CHAR_ZERO) && (i_char <= asn1tp_pkg::CHAR_NINE);
    assign is_z      = (i_char == asn1tp_pkg::CHAR_Z);
    assign is_sign   = (i_char == asn1tp_pkg::CHAR_PLUS) || (i_char == asn1tp_pkg::CHAR_MINUS);
    assign pair      = {3'b000, i_state.tens} * 7'd10 + {3'b000, digit};
    assign zone_slot = (pos == asn1tp_pkg::POS_AFTER_MIN) || (pos == asn1tp_pkg::POS_AFTER_SEC);
    assign field_off = pos - 5'd3;
    assign field_idx = field_off[3:1];

    always_comb begin
        pos = i_state.position;
        if (i_state.position == asn1tp_pkg::POS_START && !i_gen_fmt) begin
            pos = asn1tp_pkg::POS_YEAR_HI;
        end
    end

    always_comb begin
        o_state = i_state;
        if (i_state.err == asn1tp_pkg::STATUS_OK && !i_state.done) begin
            o_state.position = pos;
            if (i_state.position == asn1tp_pkg::POS_START) begin
                o_state.gen_fmt = i_gen_fmt;
            end
            if (zone_slot && is_z) begin
                o_state.zone = asn1tp_pkg::ZONE_UTC;
                o_state.done = 1'b1;
            end else if (zone_slot && is_sign) begin
                o_state.zone     = asn1tp_pkg::ZONE_NUMERIC;
                o_state.off_sign = (i_char == asn1tp_pkg::CHAR_MINUS);
                o_state.position = asn1tp_pkg::POS_OFF_H_HI;
            end else if (pos == asn1tp_pkg::POS_AFTER_SEC) begin
                o_state.done = 1'b1;
            end else if (!is_digit) begin
                o_state.err = asn1tp_pkg::STATUS_BAD_CHAR;
            end else if (pos < asn1tp_pkg::POS_AFTER_MIN) begin
                if (!pos[0]) begin
                    o_state.tens = digit;
                end else if (pos == asn1tp_pkg::POS_CENT_LO) begin
                    o_state.century = pair;
                end else begin
                    for (int k = 0; k < asn1tp_pkg::NUM_FIELDS - 1; k++) begin
                        if (field_idx == 3'(k)) begin
                            o_state.fields[k] = pair;
                        end
                    end
                end
                o_state.position = pos + 5'd1;
            end else begin
                case (pos) inside
                    asn1tp_pkg::POS_AFTER_MIN: begin
                        o_state.tens     = digit;
                        o_state.position = asn1tp_pkg::POS_SEC_LO;
                    end
                    asn1tp_pkg::POS_SEC_LO: begin
                        o_state.fields[asn1tp_pkg::NUM_FIELDS-1] = pair;
                        o_state.position = asn1tp_pkg::POS_AFTER_SEC;
                    end
                    asn1tp_pkg::POS_OFF_H_HI, asn1tp_pkg::POS_OFF_M_HI: begin
                        o_state.tens     = digit;
                        o_state.position = pos + 5'd1;
                    end
                    asn1tp_pkg::POS_OFF_H_LO: begin
                        o_state.off_hours = pair;
                        o_state.position  = asn1tp_pkg::POS_OFF_M_HI;
                    end
                    default: begin
                        o_state.off_mins = pair;
                        o_state.done     = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/asn1_time_string_parser_unit.sv
// ---------------------------------------------------------------------------
// ASN.1 time string parser
// Decodes UTCTime and GeneralizedTime strings into date, time and zone.
// ---------------------------------------------------------------------------
// The string arrives on the slave stream one ASCII byte per transfer, with
// tlast on its final byte and the format flag in tuser, taken on the first
// byte of each string. Every byte is folded into the parse state in the
// cycle of its transfer, so a byte can be taken in every cycle.
// On the transfer that carries tlast, one result is formed from the state
// after that byte and written into the output register; it appears on the
// master stream in the next cycle. The parse state returns to the start
// of a string at the same edge, so the next string may follow directly.
// Bytes flow at one per cycle; the only limit is the single output register.
// While a result waits because the receiver holds tready low, no byte is
// taken; the held result stays unchanged until its transfer.
// Reset clears the parse state and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "asn1_time_string_parser_unit_defines.svh"

module asn1_time_string_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: char_byte[7:0].
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // Fields from bit 0: gen_format[0].
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: status[1:0], year[15:2], month[22:16], day[29:23],
    // hour[36:30], minute[43:37], second[50:44], zone_kind[52:51],
    // offset_minutes[66:53], zero fill[71:67].
    output logic [asn1tp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    asn1tp_pkg::t_state r_state;
    asn1tp_pkg::t_state n_state;

    logic                                r_out_valid;
    logic [asn1tp_pkg::OUT_DATA_W-1:0]   r_out_data;
    logic [asn1tp_pkg::OUT_DATA_W-1:0]   n_out_data;

    logic        in_xfer;
    logic [1:0]  status;
    logic [13:0] year;
    logic [13:0] offset_abs;
    logic [13:0] offset;

    asn1tp_byte_step u_step (
        .i_state   (r_state),
        .i_char    (s_axis_tdata),
        .i_gen_fmt (s_axis_tuser),
        .o_state   (n_state)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (n_state.err != asn1tp_pkg::STATUS_OK) begin
            status = n_state.err;
        end else if (n_state.done) begin
            status = asn1tp_pkg::STATUS_OK;
        end else begin
            status = asn1tp_pkg::STATUS_TRUNCATED;
        end
    end

    always_comb begin
        if (n_state.gen_fmt) begin
            year = {7'd0, n_state.century} * 14'd100 + {7'd0, n_state.fields[0]};
        end else begin
            year = {7'd0, n_state.fields[0]} + ((n_state.fields[0] > 7'd50) ? 14'd1900 : 14'd2000);
        end
    end

    assign offset_abs = {7'd0, n_state.off_hours} * 14'd60 + {7'd0, n_state.off_mins};

    always_comb begin
        offset = 14'd0;
        if (n_state.zone == asn1tp_pkg::ZONE_NUMERIC) begin
            offset = n_state.off_sign ? (14'd0 - offset_abs) : offset_abs;
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[1:0] = status;
        if (status == asn1tp_pkg::STATUS_OK) begin
            n_out_data[15:2]  = year;
            n_out_data[22:16] = n_state.fields[1];
            n_out_data[29:23] = n_state.fields[2];
            n_out_data[36:30] = n_state.fields[3];
            n_out_data[43:37] = n_state.fields[4];
            n_out_data[50:44] = n_state.fields[5];
            n_out_data[52:51] = n_state.zone;
            n_out_data[66:53] = offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asn1tp_pkg::STATE_RESET;
        end else if (in_xfer) begin
            r_state <= s_axis_tlast ? asn1tp_pkg::STATE_RESET : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tlast) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `ASN1TP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_xfer && s_axis_tlast, m_axis_tvalid)
    `ASN1TP_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, in_xfer && s_axis_tlast, r_state.position == asn1tp_pkg::POS_START && !r_state.done && r_state.err == asn1tp_pkg::STATUS_OK)
    `ASN1TP_ASSERT_IMPLY(a_fail_fields_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1:0] != asn1tp_pkg::STATUS_OK, m_axis_tdata[asn1tp_pkg::OUT_DATA_W-1:2] == '0)
    `ASN1TP_ASSERT_IMPLY(a_position_range, i_clk, i_rst_n, 1'b1, r_state.position <= asn1tp_pkg::POS_OFF_M_LO)

endmodule

`default_nettype wire

### tb/sv/asn1_time_string_parser_unit_tb.sv
// ---------------------------------------------------------------------------
// ASN.1 time string parser testbench
// Streams UTCTime and GeneralizedTime strings into the parser one byte per
// transfer, predicts each decoded result from its own model of the parse,
// and checks every result transfer field by field, with and without random back pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module asn1_time_string_parser_unit_tb;

    typedef struct packed {
        logic [4:0]  fill;
        logic [13:0] offset_minutes;
        logic [1:0]  zone_kind;
        logic [6:0]  second;
        logic [6:0]  minute;
        logic [6:0]  hour;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
        logic [1:0]  status;
    } t_time_result;

    class time_parse_scoreboard;
        logic [4:0]  pos;
        logic        gen_fmt;
        logic [3:0]  tens;
        logic [6:0]  century;
        logic [6:0]  fields [asn1tp_pkg::NUM_FIELDS];
        logic [1:0]  zone;
        logic        off_neg;
        logic [6:0]  off_hours;
        logic [6:0]  off_mins;
        logic [1:0]  err;
        logic        done;
        t_time_result expected_times [$];
        int          failures;

        function new();
            failures = 0;
            clear();
        endfunction

        function void clear();
            pos = asn1tp_pkg::POS_START;
            gen_fmt = 1'b0;
            tens = '0;
            century = '0;
            foreach (fields[i]) fields[i] = '0;
            zone = asn1tp_pkg::ZONE_NONE;
            off_neg = 1'b0;
            off_hours = '0;
            off_mins = '0;
            err = asn1tp_pkg::STATUS_OK;
            done = 1'b0;
        endfunction

        function bit take_zone(logic [7:0] c);
            if (c == asn1tp_pkg::CHAR_Z) begin
                zone = asn1tp_pkg::ZONE_UTC;
                done = 1'b1;
                return 1'b1;
            end
            if (c == asn1tp_pkg::CHAR_PLUS || c == asn1tp_pkg::CHAR_MINUS) begin
                zone = asn1tp_pkg::ZONE_NUMERIC;
                off_neg = (c == asn1tp_pkg::CHAR_MINUS);
                pos = asn1tp_pkg::POS_OFF_H_HI;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_char(logic [7:0] c);
            logic [4:0] p;
            logic [3:0] d;
            logic [6:0] v;
            p = pos;
            d = c[3:0];
            if (p == asn1tp_pkg::POS_AFTER_MIN && take_zone(c)) return;
            if (p == asn1tp_pkg::POS_AFTER_SEC) begin
                if (!take_zone(c)) done = 1'b1;
                return;
            end
            if (c < asn1tp_pkg::CHAR_ZERO || c > asn1tp_pkg::CHAR_NINE) begin
                err = asn1tp_pkg::STATUS_BAD_CHAR;
                return;
            end
            v = 7'((int'(tens) * 10 + int'(d)) & 'h7f);
            if (p < asn1tp_pkg::POS_AFTER_MIN) begin
                if (!p[0]) tens = d;
                else if (p == asn1tp_pkg::POS_CENT_LO) century = v;
                else fields[(p - 5'd3) >> 1] = v;
                pos = p + 5'd1;
            end else if (p == asn1tp_pkg::POS_AFTER_MIN) begin
                tens = d;
                pos = asn1tp_pkg::POS_SEC_LO;
            end else if (p == asn1tp_pkg::POS_SEC_LO) begin
                fields[5] = v;
                pos = asn1tp_pkg::POS_AFTER_SEC;
            end else if (p == asn1tp_pkg::POS_OFF_H_HI || p == asn1tp_pkg::POS_OFF_M_HI) begin
                tens = d;
                pos = p + 5'd1;
            end else if (p == asn1tp_pkg::POS_OFF_H_LO) begin
                off_hours = v;
                pos = asn1tp_pkg::POS_OFF_M_HI;
            end else begin
                off_mins = v;
                done = 1'b1;
            end
        endfunction

        function void note_input(logic [7:0] c, logic last, logic fmt);
            t_time_result r;
            int yr;
            int off;
            if (err == asn1tp_pkg::STATUS_OK && !done) begin
                if (pos == asn1tp_pkg::POS_START) begin
                    gen_fmt = fmt;
                    if (!fmt) pos = asn1tp_pkg::POS_YEAR_HI;
                end
                take_char(c);
            end
            if (!last) return;
            r = '0;
            r.status = (err != asn1tp_pkg::STATUS_OK) ? err :
                       (done ? asn1tp_pkg::STATUS_OK : asn1tp_pkg::STATUS_TRUNCATED);
            if (r.status == asn1tp_pkg::STATUS_OK) begin
                if (gen_fmt) yr = int'(century) * 100 + int'(fields[0]);
                else yr = int'(fields[0]) + ((fields[0] > 7'd50) ? 1900 : 2000);
                off = 0;
                if (zone == asn1tp_pkg::ZONE_NUMERIC) begin
                    off = int'(off_hours) * 60 + int'(off_mins);
                    if (off_neg) off = -off;
                end
                r.year = 14'(yr);
                r.month = fields[1];
                r.day = fields[2];
                r.hour = fields[3];
                r.minute = fields[4];
                r.second = fields[5];
                r.zone_kind = zone;
                r.offset_minutes = 14'(off);
            end
            expected_times.push_back(r);
            clear();
        endfunction

        function void check_result(logic [asn1tp_pkg::OUT_DATA_W-1:0] data);
            t_time_result got;
            t_time_result want;
            got = data;
            if (expected_times.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Unexpected result transfer: %h", data);
                return;
            end
            want = expected_times.pop_front();
            if (got.status !== want.status || got.year !== want.year ||
                got.month !== want.month || got.day !== want.day ||
                got.hour !== want.hour || got.minute !== want.minute ||
                got.second !== want.second || got.zone_kind !== want.zone_kind ||
                got.offset_minutes !== want.offset_minutes || got.fill !== want.fill) begin
                failures++;
                if (failures <= 10) begin
                    $display("Mismatch: expected st=%0d y=%0d %0d-%0d %0d:%0d:%0d z=%0d off=%0d fill=%h",
                             want.status, want.year, want.month, want.day, want.hour,
                             want.minute, want.second, want.zone_kind,
                             $signed(want.offset_minutes), want.fill);
                    $display("          got st=%0d y=%0d %0d-%0d %0d:%0d:%0d z=%0d off=%0d fill=%h",
                             got.status, got.year, got.month, got.day, got.hour,
                             got.minute, got.second, got.zone_kind,
                             $signed(got.offset_minutes), got.fill);
                end
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 3000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [asn1tp_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    time_parse_scoreboard  sb = new();
    int                    sender_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    bytes_sent = 0;
    int                    quiet_cycles = 0;
    logic [7:0]            line_bytes [$];

    asn1_time_string_parser_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tlast, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic last, input logic fmt);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        s_axis_tuser <= fmt;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Only the first byte carries the real format; the flag is random after it.
    task automatic send_line(input logic fmt);
        for (int i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i], i == line_bytes.size() - 1,
                      (i == 0) ? fmt : 1'($urandom_range(1)));
    endtask

    task automatic send_text(input string text, input logic fmt);
        line_bytes.delete();
        for (int i = 0; i < text.len(); i++) line_bytes.push_back(text[i]);
        send_line(fmt);
    endtask

    function automatic logic [7:0] rand_digit();
        return asn1tp_pkg::CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic send_random_line();
        logic fmt;
        int   shape;
        int   zone_pick;
        int   n;
        fmt = 1'($urandom_range(1));
        shape = $urandom_range(99);
        line_bytes.delete();
        if (shape < 10) begin
            n = $urandom_range(1, 20);
            repeat (n) line_bytes.push_back(8'($urandom_range(255)));
        end else begin
            if (fmt) repeat (2) line_bytes.push_back(rand_digit());
            repeat (10) line_bytes.push_back(rand_digit());
            zone_pick = $urandom_range(3);
            if ($urandom_range(1)) begin
                repeat (2) line_bytes.push_back(rand_digit());
                if (zone_pick == 0 && $urandom_range(3) != 0)
                    line_bytes.push_back(8'($urandom_range(255)));
            end
            if (zone_pick == 1) line_bytes.push_back(asn1tp_pkg::CHAR_Z);
            if (zone_pick >= 2) begin
                line_bytes.push_back((zone_pick == 2) ? asn1tp_pkg::CHAR_PLUS :
                                                        asn1tp_pkg::CHAR_MINUS);
                repeat (4) line_bytes.push_back(rand_digit());
            end
            if ($urandom_range(99) < 20) begin
                n = $urandom_range(1, 3);
                repeat (n) line_bytes.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 15)
                line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(99) < 10) begin
                n = $urandom_range(1, line_bytes.size());
                while (line_bytes.size() > n) void'(line_bytes.pop_back());
            end
        end
        send_line(fmt);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("A", 1'b0);
        send_text("5", 1'b1);
        send_text("5012312359Z", 1'b0);
        send_text("5100000000", 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 53;
                    recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 53;
                end
                default: begin
                    sender_idle_pct = 9;
                    recv_stall_pct = 9;
                end
            endcase
            while (bytes_sent < 25 + 480 * (ph + 1)) send_random_line();
            if (ph == 1) begin
                // Hold the input until the output side has drained completely.
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.expected_times.size() != 0) @(posedge i_clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        while (sb.expected_times.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_times.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/asn1tp_pkg.sv
hw/rtl/asn1tp_byte_step.sv
hw/rtl/asn1_time_string_parser_unit.sv
tb/sv/asn1_time_string_parser_unit_tb.sv
